// File: rtl/prefix_expression_evaluator_assert.svh
// assertion helpers for the prefix evaluator, clocked on clk, quiet during rst
`ifndef PREFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define PREFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PXE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pxe check failed");

// next-cycle implication
`define PXE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pxe check failed");

`else

`define PXE_ASSERT_NOW(label, ante, cons)
`define PXE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/pxe_pkg.sv
package pxe_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 8;

  // character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_TIMES = 8'h2A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // status codes, first error wins
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

endpackage

// File: rtl/pxe_ram.sv
module pxe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/prefix_expression_evaluator.sv
// prefix expression evaluator
//
// input channel (in_valid / in_ready): one character word per transfer, the
// expression fed reversed, last_token set on its leftmost character. digits
// push, + * - / pop two operands and push the 8-bit wrapped result, any
// other character pops two and pushes nothing.
// output channel (out_valid / out_ready): one word per expression, sent after
// the word marked last_token: value plus status (first error seen).
// per word: a digit is pushed; + - * pop, compute and push; / runs eight
// restoring steps in the divider, skipped on a zero divisor; other
// characters pop two and finish. the last word then pops the result (none
// on an empty stack, which gives 0 and underflow) and may wait on a stalled receiver.
// the stack lives in a single-port-write, registered-read RAM, so each pop
// waits on a registered read; the sequencer takes one word at a time.
// a finished result sits in the output register while the next expression is
// taken; only the emit step of the next last word waits on a stalled
// receiver.
// reset (rst, synchronous) empties the stack, clears the error and drops
// out_valid; stack RAM contents are not cleared, only the count.
module prefix_expression_evaluator #(
  parameter int STACK_DEPTH = pxe_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     token_char,
  input  logic                           last_token,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [pxe_pkg::DATA_W-1:0] value,
  output logic [1:0]                     status
);

  import pxe_pkg::*;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP1,
    S_POP2,
    S_OPER,
    S_CALC,
    S_DIV,
    S_DIVEND,
    S_PUSH,
    S_FIN,
    S_FINW,
    S_EMIT
  } state_t;

  state_t state;

  // stack control
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_m1;
  logic [1:0]       err;
  logic             stk_full;
  logic             stk_empty;

  // current word
  logic [7:0] ch;
  logic       last;
  logic       pop1_hit;
  logic       pop2_hit;

  // operands and result
  logic signed [DATA_W-1:0]   opa;
  logic signed [DATA_W-1:0]   opb;
  logic signed [DATA_W-1:0]   res;
  logic signed [2*DATA_W-1:0] prod;

  // restoring divider
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [2:0]        step;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_diff;
  logic              rem_ge;
  logic [DATA_W-1:0] abs_a;
  logic [DATA_W-1:0] abs_b;

  // ram port
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_W-1:0]     ram_rdata;

  // result goes out this cycle
  logic                  emit_go;

  assign in_ready  = (state == S_IDLE);
  assign cnt_m1    = cnt - CNT_W'(1);
  assign stk_full  = (cnt == CNT_W'(STACK_DEPTH));
  assign stk_empty = (cnt == '0);
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);

  // top of stack is always the read address; write lands at cnt
  assign ram_raddr = cnt_m1[ADDR_W-1:0];
  assign ram_waddr = cnt[ADDR_W-1:0];
  assign ram_we    = (state == S_PUSH) && !stk_full;

  assign prod     = opa * opb;
  assign abs_a    = opa[DATA_W-1] ? DATA_W'(-opa) : DATA_W'(opa);
  assign abs_b    = opb[DATA_W-1] ? DATA_W'(-opb) : DATA_W'(opb);
  assign rem_sh   = {rem, quo[DATA_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, dvs});
  assign rem_diff = rem_sh - {1'b0, dvs};

  pxe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (res),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      // a new result replacing the taken one keeps out_valid high
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch   <= token_char;
            last <= last_token;
            if (token_char >= CHAR_ZERO && token_char <= CHAR_NINE) begin
              res   <= token_char - CHAR_ZERO;
              state <= S_PUSH;
            end else begin
              state <= S_POP1;
            end
          end
        end
        // first operand: read issued here, data lands in S_POP2
        S_POP1: begin
          pop1_hit <= !stk_empty;
          if (stk_empty) begin
            if (err == ST_OK) err <= ST_UNDER;
          end else begin
            cnt <= cnt_m1;
          end
          state <= S_POP2;
        end
        S_POP2: begin
          opa      <= pop1_hit ? ram_rdata : '0;
          pop2_hit <= !stk_empty;
          if (stk_empty) begin
            if (err == ST_OK) err <= ST_UNDER;
          end else begin
            cnt <= cnt_m1;
          end
          state <= S_OPER;
        end
        S_OPER: begin
          opb   <= pop2_hit ? ram_rdata : '0;
          state <= S_CALC;
        end
        S_CALC: begin
          case (ch)
            CHAR_PLUS: begin
              res   <= opa + opb;
              state <= S_PUSH;
            end
            CHAR_MINUS: begin
              res   <= opa - opb;
              state <= S_PUSH;
            end
            CHAR_TIMES: begin
              res   <= prod[DATA_W-1:0];
              state <= S_PUSH;
            end
            CHAR_SLASH: begin
              if (opb == '0) begin
                if (err == ST_OK) err <= ST_DIV0;
                res   <= '0;
                state <= S_PUSH;
              end else begin
                rem   <= '0;
                quo   <= abs_a;
                dvs   <= abs_b;
                neg   <= opa[DATA_W-1] ^ opb[DATA_W-1];
                step  <= '0;
                state <= S_DIV;
              end
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        // one quotient bit per cycle, msb first
        S_DIV: begin
          if (rem_ge) begin
            rem <= rem_diff[DATA_W-1:0];
            quo <= {quo[DATA_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[DATA_W-1:0];
            quo <= {quo[DATA_W-2:0], 1'b0};
          end
          step <= step + 3'd1;
          if (step == 3'(DATA_W - 1)) begin
            state <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          res   <= neg ? DATA_W'(-quo) : quo;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (stk_full) begin
            if (err == ST_OK) err <= ST_OVER;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (stk_empty) begin
            if (err == ST_OK) err <= ST_UNDER;
            res   <= '0;
            state <= S_EMIT;
          end else begin
            cnt   <= cnt_m1;
            state <= S_FINW;
          end
        end
        S_FINW: begin
          res   <= ram_rdata;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            value     <= res;
            status    <= err;
            out_valid <= 1'b1;
            cnt       <= '0;
            err       <= ST_OK;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "prefix_expression_evaluator_assert.svh"

  `PXE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CNT_W'(STACK_DEPTH))
  `PXE_ASSERT_NOW(a_no_write_full, ram_we, cnt < CNT_W'(STACK_DEPTH))
  `PXE_ASSERT_NEXT(a_emit_clears, emit_go, (cnt == '0) && (err == ST_OK) && out_valid)

endmodule
